// ----- hdl/bbn_pkg.sv -----
// bbn_pkg: shared types and constants for the bounding box normalize unit
// used by every module under hdl
package bbn_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned CoordW = 32;
  localparam int unsigned NormW = 19;
  localparam int unsigned SpanW = 33;
  localparam int unsigned NumW = 52;
  localparam int unsigned QuoW = 20;
  localparam int unsigned OutLimit = 131072;

  typedef enum logic [2:0] {
    StLoad,
    StSpan,
    StRead,
    StDiv,
    StEmit
  } state_e;

  typedef struct packed {
    logic start;
    logic bypass;
  } lane_ctl_t;

endpackage

// ----- hdl/bbn_lane.sv -----
// bbn_lane: one axis lane, bounds tracking and bit-serial signed divide
// depends on bbn_pkg
module bbn_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic                                first_i,
  input  logic                                clear_i,
  input  logic signed [bbn_pkg::CoordW-1:0]   vtx_i,
  input  logic        [bbn_pkg::SpanW-1:0]    span_i,
  input  bbn_pkg::lane_ctl_t                  ctl_i,
  output logic        [bbn_pkg::SpanW-1:0]    range_o,
  output logic                                done_o,
  output logic signed [bbn_pkg::NormW-1:0]    norm_o
);

  logic signed [bbn_pkg::CoordW-1:0] lo_q, hi_q;
  logic [bbn_pkg::NumW-1:0] rem_q, rem_d;
  logic [bbn_pkg::NumW-1:0] quo_q, quo_d;
  logic [bbn_pkg::SpanW-1:0] div_q;
  logic neg_q, busy_q, done_q;
  logic [5:0] cnt_q;
  logic signed [bbn_pkg::NormW-1:0] norm_q;
  logic signed [bbn_pkg::SpanW+1:0] diff;
  logic signed [bbn_pkg::NumW-1:0] num;
  logic [bbn_pkg::NumW:0] trial;
  logic signed [bbn_pkg::QuoW:0] sq;

  assign range_o = bbn_pkg::SpanW'($signed({hi_q[bbn_pkg::CoordW-1], hi_q})
                 - $signed({lo_q[bbn_pkg::CoordW-1], lo_q}));

  assign diff = ($signed({{3{vtx_i[bbn_pkg::CoordW-1]}}, vtx_i}) <<< 1)
              - $signed({{3{lo_q[bbn_pkg::CoordW-1]}}, lo_q})
              - $signed({{3{hi_q[bbn_pkg::CoordW-1]}}, hi_q});
  assign num = $signed({diff, 17'd0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (clear_i) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (load_i) begin
      if (first_i || vtx_i < lo_q) lo_q <= vtx_i;
      if (first_i || vtx_i > hi_q) hi_q <= vtx_i;
    end
  end

  always_comb begin
    trial = {rem_q[bbn_pkg::NumW-2:0], quo_q[bbn_pkg::NumW-1]}
          - {{(bbn_pkg::NumW-bbn_pkg::SpanW+1){1'b0}}, div_q};
    if (!trial[bbn_pkg::NumW]) begin
      rem_d = trial[bbn_pkg::NumW-1:0];
      quo_d = {quo_q[bbn_pkg::NumW-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[bbn_pkg::NumW-2:0], quo_q[bbn_pkg::NumW-1]};
      quo_d = {quo_q[bbn_pkg::NumW-2:0], 1'b0};
    end
  end

  // quotient magnitude is within 2^17 once the numerator is in range
  assign sq = neg_q ? -$signed({1'b0, quo_q[bbn_pkg::QuoW-1:0]})
                    : $signed({1'b0, quo_q[bbn_pkg::QuoW-1:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        if (ctl_i.bypass) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(bbn_pkg::NumW-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= '0;
      quo_q <= num[bbn_pkg::NumW-1] ? bbn_pkg::NumW'(-num) : bbn_pkg::NumW'(num);
      neg_q <= num[bbn_pkg::NumW-1];
      div_q <= span_i;
      if (vtx_i > $signed(bbn_pkg::CoordW'(bbn_pkg::OutLimit)))
        norm_q <= bbn_pkg::NormW'(bbn_pkg::OutLimit);
      else if (vtx_i < -$signed(bbn_pkg::CoordW'(bbn_pkg::OutLimit)))
        norm_q <= -bbn_pkg::NormW'(bbn_pkg::OutLimit);
      else
        norm_q <= vtx_i[bbn_pkg::NormW-1:0];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end else if (done_q && !ctl_i.bypass) begin
      norm_q <= sq[bbn_pkg::NormW-1:0];
    end
  end

  assign done_o = done_q;
  assign norm_o = norm_q;

endmodule

// ----- hdl/bbn_merge.sv -----
// bbn_merge: picks the largest axis span from the three lanes
// depends on bbn_pkg
module bbn_merge (
  input  logic                             clk_i,
  input  logic                             take_i,
  input  logic [bbn_pkg::SpanW-1:0]        range_x_i,
  input  logic [bbn_pkg::SpanW-1:0]        range_y_i,
  input  logic [bbn_pkg::SpanW-1:0]        range_z_i,
  output logic [bbn_pkg::SpanW-1:0]        span_o,
  output logic                             zero_o
);

  logic [bbn_pkg::SpanW-1:0] m_xy, span_q;

  assign m_xy = (range_y_i > range_x_i) ? range_y_i : range_x_i;

  always_ff @(posedge clk_i) begin
    if (take_i) span_q <= (range_z_i > m_xy) ? range_z_i : m_xy;
  end

  assign span_o = span_q;
  assign zero_o = (span_q == '0);

endmodule

// ----- hdl/bounding_box_normalize_unit.sv -----
// bounding_box_normalize_unit: top level, vertex buffer, control and lanes
// depends on bbn_pkg, bbn_lane, bbn_merge
// Load takes one vertex per cycle (busy stays low). A vertex marked final
// starts the emit: the span state forms the span, then per stored vertex
// come a buffer read, the bit-serial divide and a latch of the quotient
// (all three axes in parallel lanes) and the output state. With zero span
// the divide is skipped. Results cannot be held off: each appears for one
// cycle with valid_o.
module bounding_box_normalize_unit #(
  parameter int unsigned MaxVertices = bbn_pkg::MaxVerticesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bbn_pkg::CoordW-1:0]   vertex_x_i,
  input  logic signed [bbn_pkg::CoordW-1:0]   vertex_y_i,
  input  logic signed [bbn_pkg::CoordW-1:0]   vertex_z_i,
  input  logic                                is_final_i,
  output logic                                valid_o,
  output logic signed [bbn_pkg::NormW-1:0]    norm_x_o,
  output logic signed [bbn_pkg::NormW-1:0]    norm_y_o,
  output logic signed [bbn_pkg::NormW-1:0]    norm_z_o,
  output logic                                run_end_o
);

  localparam int unsigned AddrW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CntW = $clog2(MaxVertices + 1);

  logic [bbn_pkg::CoordW-1:0] mem_x [MaxVertices];
  logic [bbn_pkg::CoordW-1:0] mem_y [MaxVertices];
  logic [bbn_pkg::CoordW-1:0] mem_z [MaxVertices];
  logic signed [bbn_pkg::CoordW-1:0] rd_x_q, rd_y_q, rd_z_q;

  bbn_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, idx_q, rd_idx;
  logic accept, load, clear, room;
  bbn_pkg::lane_ctl_t ctl;
  logic [bbn_pkg::SpanW-1:0] rx, ry, rz, span;
  logic span_zero, dx, dy, dz;

  assign accept = start && !busy;
  assign room   = (count_q != CntW'(MaxVertices));
  assign load   = accept && room;
  assign busy   = (state_q != bbn_pkg::StLoad);

  assign rd_idx = (state_q == bbn_pkg::StSpan) ? '0 :
                  (state_q == bbn_pkg::StEmit) ? idx_q + CntW'(1) : idx_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      mem_x[count_q[AddrW-1:0]] <= vertex_x_i;
      mem_y[count_q[AddrW-1:0]] <= vertex_y_i;
      mem_z[count_q[AddrW-1:0]] <= vertex_z_i;
    end
    rd_x_q <= mem_x[rd_idx[AddrW-1:0]];
    rd_y_q <= mem_y[rd_idx[AddrW-1:0]];
    rd_z_q <= mem_z[rd_idx[AddrW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbn_pkg::StLoad: begin
        if (accept && is_final_i) state_d = (room || count_q != '0) ?
                                            bbn_pkg::StSpan : bbn_pkg::StLoad;
      end
      bbn_pkg::StSpan: state_d = bbn_pkg::StRead;
      bbn_pkg::StRead: state_d = bbn_pkg::StDiv;
      bbn_pkg::StDiv:  if (dx && dy && dz) state_d = bbn_pkg::StEmit;
      bbn_pkg::StEmit: state_d = (idx_q + CntW'(1) == count_q) ?
                                 bbn_pkg::StLoad : bbn_pkg::StRead;
      default: state_d = bbn_pkg::StLoad;
    endcase
  end

  always_comb begin
    ctl.start  = (state_q == bbn_pkg::StRead);
    ctl.bypass = span_zero;
    clear      = (state_q == bbn_pkg::StEmit) && (idx_q + CntW'(1) == count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbn_pkg::StLoad;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load) count_q <= count_q + CntW'(1);
      if (state_q == bbn_pkg::StSpan) idx_q <= '0;
      if (state_q == bbn_pkg::StEmit) idx_q <= idx_q + CntW'(1);
      if (clear) count_q <= '0;
    end
  end

  // read address is set in the state before the lane start, rd regs feed lanes
  bbn_lane u_lane_x (
    .clk_i, .rst_ni, .load_i(load), .first_i(count_q == '0), .clear_i(clear),
    .vtx_i(busy ? rd_x_q : vertex_x_i), .span_i(span), .ctl_i(ctl),
    .range_o(rx), .done_o(dx), .norm_o(norm_x_o)
  );
  bbn_lane u_lane_y (
    .clk_i, .rst_ni, .load_i(load), .first_i(count_q == '0), .clear_i(clear),
    .vtx_i(busy ? rd_y_q : vertex_y_i), .span_i(span), .ctl_i(ctl),
    .range_o(ry), .done_o(dy), .norm_o(norm_y_o)
  );
  bbn_lane u_lane_z (
    .clk_i, .rst_ni, .load_i(load), .first_i(count_q == '0), .clear_i(clear),
    .vtx_i(busy ? rd_z_q : vertex_z_i), .span_i(span), .ctl_i(ctl),
    .range_o(rz), .done_o(dz), .norm_o(norm_z_o)
  );

  bbn_merge u_merge (
    .clk_i, .take_i(state_q == bbn_pkg::StSpan),
    .range_x_i(rx), .range_y_i(ry), .range_z_i(rz),
    .span_o(span), .zero_o(span_zero)
  );

  assign valid_o   = (state_q == bbn_pkg::StEmit);
  assign run_end_o = valid_o && (idx_q + CntW'(1) == count_q);

endmodule

// ----- hdl/bbn_checker.sv -----
// bbn_checker: port-level checks for bounding_box_normalize_unit
// depends on bbn_pkg
module bbn_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             valid_o,
  input logic signed [bbn_pkg::NormW-1:0] norm_x_o,
  input logic                             run_end_o
);

  a_end_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end_o |-> valid_o) else $error("run end without valid");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result outside emit");
  a_end_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end_o |=> !busy) else $error("busy after run end");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (norm_x_o <= 19'sd131072 && norm_x_o >= -19'sd131072))
    else $error("x out of range");
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> !valid_o) else $error("result during load beat");

endmodule

bind bounding_box_normalize_unit bbn_checker u_bbn_checker (
  .clk_i, .rst_ni, .start, .busy, .valid_o, .norm_x_o, .run_end_o
);

// ----- dv/testbench.sv -----
// testbench: drives vertex sets into bounding_box_normalize_unit and checks every
// normalized vertex against an in-bench prediction; depends on bbn_pkg and the rtl
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic signed [bbn_pkg::NormW-1:0] nx;
    logic signed [bbn_pkg::NormW-1:0] ny;
    logic signed [bbn_pkg::NormW-1:0] nz;
    logic                             last;
  } norm_vertex_t;

  class norm_scoreboard;
    logic signed [bbn_pkg::CoordW-1:0] vx_mem[bbn_pkg::MaxVerticesDef];
    logic signed [bbn_pkg::CoordW-1:0] vy_mem[bbn_pkg::MaxVerticesDef];
    logic signed [bbn_pkg::CoordW-1:0] vz_mem[bbn_pkg::MaxVerticesDef];
    logic signed [bbn_pkg::CoordW-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    int unsigned                       fill;
    norm_vertex_t                      pending[$];
    int unsigned                       errors;

    function new();
      fill = 0;
      errors = 0;
      lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; lo_z = 0; hi_z = 0;
    endfunction

    function logic signed [bbn_pkg::NormW-1:0] clamp_norm(longint v);
      if (v > longint'(bbn_pkg::OutLimit)) v = longint'(bbn_pkg::OutLimit);
      if (v < -longint'(bbn_pkg::OutLimit)) v = -longint'(bbn_pkg::OutLimit);
      return v[bbn_pkg::NormW-1:0];
    endfunction

    function longint scale_axis(longint v, longint lo, longint hi, longint span);
      longint num;
      num = (2 * v - lo - hi) * 131072;
      return num / span;
    endfunction

    function void note_vertex(logic signed [bbn_pkg::CoordW-1:0] x,
                              logic signed [bbn_pkg::CoordW-1:0] y,
                              logic signed [bbn_pkg::CoordW-1:0] z, logic fin);
      longint sx, sy, sz, span;
      norm_vertex_t e;
      if (fill < bbn_pkg::MaxVerticesDef) begin
        if (fill == 0) begin
          lo_x = x; hi_x = x; lo_y = y; hi_y = y; lo_z = z; hi_z = z;
        end else begin
          if (x < lo_x) lo_x = x;
          if (x > hi_x) hi_x = x;
          if (y < lo_y) lo_y = y;
          if (y > hi_y) hi_y = y;
          if (z < lo_z) lo_z = z;
          if (z > hi_z) hi_z = z;
        end
        vx_mem[fill] = x;
        vy_mem[fill] = y;
        vz_mem[fill] = z;
        fill++;
      end
      if (!fin) return;
      sx = longint'(hi_x) - longint'(lo_x);
      sy = longint'(hi_y) - longint'(lo_y);
      sz = longint'(hi_z) - longint'(lo_z);
      span = sx;
      if (sy > span) span = sy;
      if (sz > span) span = sz;
      for (int i = 0; i < fill; i++) begin
        if (span > 0) begin
          e.nx = clamp_norm(scale_axis(vx_mem[i], lo_x, hi_x, span));
          e.ny = clamp_norm(scale_axis(vy_mem[i], lo_y, hi_y, span));
          e.nz = clamp_norm(scale_axis(vz_mem[i], lo_z, hi_z, span));
        end else begin
          e.nx = clamp_norm(vx_mem[i]);
          e.ny = clamp_norm(vy_mem[i]);
          e.nz = clamp_norm(vz_mem[i]);
        end
        e.last = (i + 1 == fill);
        pending.insert(pending.size(), e);
      end
      fill = 0;
      lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; lo_z = 0; hi_z = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_vertex(norm_vertex_t got);
      norm_vertex_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result beat");
        return;
      end
      e = pending.pop_front();
      if (got.nx !== e.nx)
        report_mismatch($sformatf("norm_x got %0d exp %0d", got.nx, e.nx));
      if (got.ny !== e.ny)
        report_mismatch($sformatf("norm_y got %0d exp %0d", got.ny, e.ny));
      if (got.nz !== e.nz)
        report_mismatch($sformatf("norm_z got %0d exp %0d", got.nz, e.nz));
      if (got.last !== e.last)
        report_mismatch($sformatf("run_end got %0b exp %0b", got.last, e.last));
    endtask
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic signed [bbn_pkg::CoordW-1:0] vertex_x_i = '0;
  logic signed [bbn_pkg::CoordW-1:0] vertex_y_i = '0;
  logic signed [bbn_pkg::CoordW-1:0] vertex_z_i = '0;
  logic                              is_final_i = 1'b0;
  logic                              valid_o;
  logic signed [bbn_pkg::NormW-1:0]  norm_x_o, norm_y_o, norm_z_o;
  logic                              run_end_o;

  norm_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    sent = 0;

  always #1 clk_i = ~clk_i;

  bounding_box_normalize_unit dut (
    .clk_i, .rst_ni, .start, .busy, .vertex_x_i, .vertex_y_i, .vertex_z_i,
    .is_final_i, .valid_o, .norm_x_o, .norm_y_o, .norm_z_o, .run_end_o
  );

  always @(posedge clk_i) begin
    norm_vertex_t got;
    cycles++;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && valid_o) begin
      got.nx = norm_x_o;
      got.ny = norm_y_o;
      got.nz = norm_z_o;
      got.last = run_end_o;
      sb.check_vertex(got);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_vertex(logic signed [bbn_pkg::CoordW-1:0] x,
                             logic signed [bbn_pkg::CoordW-1:0] y,
                             logic signed [bbn_pkg::CoordW-1:0] z, logic fin);
    int unsigned gap;
    start <= 1'b1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    vertex_z_i <= z;
    is_final_i <= fin;
    do @(posedge clk_i); while (busy);
    sb.note_vertex(x, y, z, fin);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic signed [bbn_pkg::CoordW-1:0] pick_coord(int mode, int base);
    case (mode)
      0: return $urandom;
      1: return base + $urandom_range(0, 4000) - 2000;
      2: return base;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic send_set(int unsigned n, int mode);
    int bx, by, bz;
    bx = int'($urandom_range(0, 32'h7fff_0000)) - 32'h3fff_8000;
    by = int'($urandom_range(0, 32'h7fff_0000)) - 32'h3fff_8000;
    bz = int'($urandom_range(0, 32'h7fff_0000)) - 32'h3fff_8000;
    for (int unsigned i = 0; i < n; i++)
      send_vertex(pick_coord(mode, bx), pick_coord(mode, by), pick_coord(mode, bz),
                  i + 1 == n);
  endtask

  initial begin
    int unsigned n;
    int          mode;
    int          big_sets;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of every axis
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_vertex(0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    // single vertex, zero span with saturation
    send_vertex(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, 1'b1);
    // zero span, in-range values
    send_vertex(32'sh0000_1234, -32'sh0001_8000, 32'sh0000_0000, 1'b0);
    send_vertex(32'sh0000_1234, -32'sh0001_8000, 32'sh0000_0000, 1'b1);
    // span on x only
    send_vertex(32'sh0001_0000, 32'sh0000_0005, -32'sh0000_0007, 1'b0);
    send_vertex(-32'sh0003_0000, 32'sh0000_0005, -32'sh0000_0007, 1'b0);
    send_vertex(32'sh0000_4000, 32'sh0000_0005, -32'sh0000_0007, 1'b1);
    // span of one lsb
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(1, 0, 1, 1'b1);
    drain_results();

    big_sets = 0;
    while (sent < 265) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
      if (big_sets < 2 && $urandom_range(0, 9) == 0) begin
        // overflow: loads past the buffer depth are dropped
        n = bbn_pkg::MaxVerticesDef + $urandom_range(0, 3);
        big_sets++;
      end else begin
        n = $urandom_range(1, 8);
      end
      send_set(n, mode);
      if ($urandom_range(0, 5) == 0) drain_results();
    end
    drain_results();

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
